FILE: rtl/lmpm_pkg.sv
// Package for the LED matrix pixel mapper.
// Shared types, codes and fixed field widths; no dependencies.
package lmpm_pkg;

  localparam int PIX_W  = 8;   // pixel coordinate width
  localparam int COL_W  = 16;  // colour width
  localparam int UW_W   = 4;   // unit_width register width
  localparam int UH_W   = 5;   // unit_height register width
  localparam int UA_W   = 5;   // units_across register width
  localparam int UNIT_W = PIX_W + UA_W + 1;   // qy * across + qx
  localparam int IDX_W  = UNIT_W + UH_W + 1;  // line + uh * unit
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [COL_W-1:0] LIT_LEVEL = 16'h00ff;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_BOUNDS = 2'd1,
    ERR_STORE  = 2'd2
  } err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATRIX_WIDTH  = 4'd0,
    REG_MATRIX_HEIGHT = 4'd1,
    REG_UNITS_ACROSS  = 4'd2,
    REG_UNIT_WIDTH    = 4'd3,
    REG_UNIT_HEIGHT   = 4'd4,
    REG_BIT_REMAP     = 4'd5,
    REG_LINE_REMAP    = 4'd6,
    REG_WRITE_THROUGH = 4'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_UNIT,
    S_INDEX,
    S_FETCH,
    S_UPDATE
  } state_t;

endpackage

FILE: rtl/lmpm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lmpm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/lmpm_div.sv
// Restoring divider, one quotient bit per cycle, for pixel coordinates.
// Depends on lmpm_pkg (PIX_W).
module lmpm_div
  import lmpm_pkg::*;
#(
  parameter int DIV_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [PIX_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [PIX_W-1:0] quotient,
  output logic [DIV_W-1:0] remainder
);

  localparam int CNT_W = $clog2(PIX_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W:0]   trial;
  logic             take;

  assign trial = {remainder, quotient[PIX_W-1]};
  assign take  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(PIX_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient register shifts the dividend out, quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      if (take) begin
        remainder <= DIV_W'(trial - {1'b0, dsr});
      end else begin
        remainder <= trial[DIV_W-1:0];
      end
      quotient <= {quotient[PIX_W-2:0], take};
    end
  end

endmodule

FILE: rtl/led_matrix_pixel_mapper.sv
// LED matrix pixel mapper: maps (x,y) to unit/line/bit, keeps live and shadow line stores.
// Each word steps through S_DIV (8-step coordinate dividers), S_UNIT, S_INDEX, S_FETCH
// and S_UPDATE (memory RMW); out-of-bounds words go to S_UPDATE. Words enter in S_IDLE.
// Reset (rst, synchronous, active high) loads register defaults and marks both
// stores empty through per-entry valid bits; no clearing pass is needed.
// Depends on lmpm_pkg, lmpm_div, lmpm_ram.
module led_matrix_pixel_mapper
  import lmpm_pkg::*;
#(
  parameter int STORE_DEPTH = 64,
  parameter int MAX_UNITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // draw/read words in
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  opcode,
  input  logic [PIX_W-1:0]      pixel_x,
  input  logic [PIX_W-1:0]      pixel_y,
  input  logic [COL_W-1:0]      colour,
  // result words out
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  unit_write,
  output logic [3:0]            unit_index,
  output logic [3:0]            line_address,
  output logic [7:0]            segment_bits,
  output logic                  pixel_lit,
  output logic [1:0]            error_code,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [PIX_W-1:0] matrix_width, matrix_height;
  logic [UA_W-1:0]  units_across;
  logic [UW_W-1:0]  unit_width;
  logic [UH_W-1:0]  unit_height;
  logic [23:0]      bit_remap;
  logic [63:0]      line_remap;
  logic             write_through;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_width  <= 8'd35;
      matrix_height <= 8'd11;
      units_across  <= 5'd5;
      unit_width    <= 4'd7;
      unit_height   <= 5'd11;
      bit_remap     <= 24'hFAC688;
      line_remap    <= 64'hFEDCBA9876543210;
      write_through <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_MATRIX_WIDTH:  matrix_width  <= cfg_data[PIX_W-1:0];
        REG_MATRIX_HEIGHT: matrix_height <= cfg_data[PIX_W-1:0];
        REG_UNITS_ACROSS:  units_across  <= cfg_data[UA_W-1:0];
        REG_UNIT_WIDTH:    unit_width    <= cfg_data[UW_W-1:0];
        REG_UNIT_HEIGHT:   unit_height   <= cfg_data[UH_W-1:0];
        REG_BIT_REMAP:     bit_remap     <= cfg_data[23:0];
        REG_LINE_REMAP:    line_remap    <= cfg_data;
        REG_WRITE_THROUGH: write_through <= cfg_data[0];
        default: ;  // indexes beyond the list are dropped
      endcase
    end
  end

  // zero-sized unit behaves as size one
  logic [UW_W-1:0] uw;
  logic [UH_W-1:0] uh;
  assign uw = (unit_width  == '0) ? UW_W'(1) : unit_width;
  assign uh = (unit_height == '0) ? UH_W'(1) : unit_height;

  // ---------------------------------------------------------------------
  // Captured word and pipeline registers
  // ---------------------------------------------------------------------
  state_t           state, state_next;
  logic             op_r;
  logic [COL_W-1:0] colour_r;
  err_t             err_r;
  logic [UNIT_W-1:0] unit_r;
  logic [3:0]       line_r;
  logic [2:0]       bit_r;
  logic [IDX_W-1:0] idx_r;
  logic             use_live;   // which store feeds the read-modify-write
  logic             vld_r;      // entry had been written since reset

  logic accept, oob, store_bad, out_free, commit;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign oob       = (pixel_x >= matrix_width) || (pixel_y >= matrix_height);
  assign store_bad = (idx_r >= IDX_W'(STORE_DEPTH)) || (unit_r >= UNIT_W'(MAX_UNITS));
  assign out_free  = !out_valid || !out_stall;
  assign commit    = (state == S_UPDATE) && out_free;

  // ---------------------------------------------------------------------
  // Coordinate dividers: x by unit width, y by unit height, in parallel
  // ---------------------------------------------------------------------
  logic             div_start;
  logic             x_done, y_done;
  logic [PIX_W-1:0] qx, qy;
  logic [UW_W-1:0]  rx;
  logic [UH_W-1:0]  ry;

  assign div_start = accept && !oob;

  lmpm_div #(.DIV_W(UW_W)) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (pixel_x),
    .divisor   (uw),
    .done      (x_done),
    .quotient  (qx),
    .remainder (rx)
  );

  lmpm_div #(.DIV_W(UH_W)) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (pixel_y),
    .divisor   (uh),
    .done      (y_done),
    .quotient  (qy),
    .remainder (ry)
  );

  // ---------------------------------------------------------------------
  // Line stores. Per-entry valid bits stand in for the reset clear.
  // ---------------------------------------------------------------------
  logic [AW-1:0]          addr;
  logic                   rd_en;
  logic                   live_we, shadow_we;
  logic [7:0]             live_rd, shadow_rd;
  logic [7:0]             old_byte, new_byte, mask;
  logic [STORE_DEPTH-1:0] live_vld, shadow_vld;

  assign addr  = idx_r[AW-1:0];
  assign rd_en = (state == S_FETCH) && !store_bad;

  lmpm_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_live (
    .clk   (clk),
    .we    (live_we),
    .waddr (addr),
    .wdata (new_byte),
    .re    (rd_en),
    .raddr (addr),
    .rdata (live_rd)
  );

  lmpm_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_shadow (
    .clk   (clk),
    .we    (shadow_we),
    .waddr (addr),
    .wdata (new_byte),
    .re    (rd_en),
    .raddr (addr),
    .rdata (shadow_rd)
  );

  assign mask     = 8'd1 << bit_r;
  assign old_byte = !vld_r ? 8'd0 : (use_live ? live_rd : shadow_rd);
  assign new_byte = (colour_r >= LIT_LEVEL) ? (old_byte | mask) : (old_byte & ~mask);

  // only one word is in flight and its write lands before the next read,
  // so no forwarding path is needed
  assign live_we   = commit && (err_r == ERR_OK) && (op_r == OP_DRAW) && write_through;
  assign shadow_we = commit && (err_r == ERR_OK) && (op_r == OP_DRAW) && !write_through;

  always_ff @(posedge clk) begin
    if (rst) begin
      live_vld   <= '0;
      shadow_vld <= '0;
    end else begin
      if (live_we) begin
        live_vld[addr] <= 1'b1;
      end
      if (shadow_we) begin
        shadow_vld[addr] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = oob ? S_UPDATE : S_DIV;
        end
      end
      S_DIV: begin
        if (x_done) begin
          state_next = S_UNIT;
        end
      end
      S_UNIT:   state_next = S_INDEX;
      S_INDEX:  state_next = S_FETCH;
      S_FETCH:  state_next = S_UPDATE;
      S_UPDATE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // datapath registers: unit multiply in S_UNIT, index multiply in S_INDEX
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= opcode;
      colour_r <= colour;
      err_r    <= oob ? ERR_BOUNDS : ERR_OK;
    end
    if (state == S_UNIT) begin
      unit_r <= UNIT_W'(UNIT_W'(qy) * UNIT_W'(units_across)) + UNIT_W'(qx);
      line_r <= line_remap[{ry[3:0], 2'b00} +: 4];
      bit_r  <= bit_remap[5'(rx[2:0]) * 5'd3 +: 3];
    end
    if (state == S_INDEX) begin
      idx_r <= IDX_W'(IDX_W'(uh) * IDX_W'(unit_r)) + IDX_W'(line_r);
    end
    if (state == S_FETCH) begin
      use_live <= (op_r == OP_READ) || write_through;
      if (store_bad) begin
        err_r <= ERR_STORE;
        vld_r <= 1'b0;
      end else begin
        vld_r <= ((op_r == OP_READ) || write_through) ? live_vld[addr] : shadow_vld[addr];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register: lets the next word in while a result waits
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      error_code <= err_r;
      if (err_r != ERR_OK) begin
        unit_write   <= 1'b0;
        unit_index   <= '0;
        line_address <= '0;
        segment_bits <= '0;
        pixel_lit    <= 1'b0;
      end else begin
        unit_index   <= unit_r[3:0];
        line_address <= line_r;
        if (op_r == OP_READ) begin
          unit_write   <= 1'b0;
          segment_bits <= old_byte;
          pixel_lit    <= |(old_byte & mask);
        end else begin
          unit_write   <= write_through;
          segment_bits <= new_byte;
          pixel_lit    <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_one_store_written: assert property (@(posedge clk) disable iff (rst)
    !(live_we && shadow_we))
    else $error("both stores written in one cycle");

  a_write_only_ok: assert property (@(posedge clk) disable iff (rst)
    (live_we || shadow_we) |-> (err_r == ERR_OK && state == S_UPDATE))
    else $error("store written for a faulted word");

  a_dividers_aligned: assert property (@(posedge clk) disable iff (rst)
    x_done == y_done)
    else $error("coordinate dividers out of step");

  a_result_not_clobbered: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE && out_valid && out_stall) |=> (state == S_UPDATE))
    else $error("result loaded over a pending word");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("second word taken while one is in flight");

endmodule

FILE: bench/tb_led_matrix_pixel_mapper.sv
`timescale 1ns / 100ps
// Testbench for led_matrix_pixel_mapper: draw and read words under several layouts,
// checked against an in-bench model of the live and shadow line stores.
// Depends on lmpm_pkg and the mapper RTL.
module tb_led_matrix_pixel_mapper;
  import lmpm_pkg::*;

  localparam int DEPTH         = 64;
  localparam int UNITS_MAX     = 16;
  localparam int LATENCY       = 14;      // sizes the settling wait before the verdict
  localparam int CYCLE_LIMIT   = 400000;  // far beyond the slowest legal run
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_WORDS   = 100;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic                  opcode;
  logic [PIX_W-1:0]      pixel_x;
  logic [PIX_W-1:0]      pixel_y;
  logic [COL_W-1:0]      colour;
  logic                  out_valid;
  logic                  out_stall;
  logic                  unit_write;
  logic [3:0]            unit_index;
  logic [3:0]            line_address;
  logic [7:0]            segment_bits;
  logic                  pixel_lit;
  logic [1:0]            error_code;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  led_matrix_pixel_mapper #(
    .STORE_DEPTH(DEPTH),
    .MAX_UNITS  (UNITS_MAX)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .colour      (colour),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .unit_write  (unit_write),
    .unit_index  (unit_index),
    .line_address(line_address),
    .segment_bits(segment_bits),
    .pixel_lit   (pixel_lit),
    .error_code  (error_code),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // One result word as the block should produce it.
  typedef struct {
    logic       unit_write;
    logic [3:0] unit_index;
    logic [3:0] line_address;
    logic [7:0] segment_bits;
    logic       pixel_lit;
    err_t       err;
  } pixel_result_t;

  // Results owed by the block, oldest first.
  pixel_result_t pending[$];

  // Bench copy of the layout registers.
  logic [7:0]  mat_w;
  logic [7:0]  mat_h;
  logic [4:0]  across;
  logic [3:0]  unit_w;
  logic [4:0]  unit_h;
  logic [23:0] bit_map;
  logic [63:0] line_map;
  logic        wr_through;

  // Bench copy of both line stores.
  logic [7:0] live_store   [DEPTH];
  logic [7:0] shadow_store [DEPTH];

  int errors;
  int cycles;
  bit idle_on;   // random gaps and stalls enabled

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Pixel mapping model. Updates the bench stores and returns the result word.
  // ---------------------------------------------------------------------------
  function automatic pixel_result_t map_pixel(logic op, logic [7:0] x, logic [7:0] y,
                                               logic [15:0] c);
    pixel_result_t r;
    int unsigned   uw;
    int unsigned   uh;
    int unsigned   unit;
    int unsigned   line;
    int unsigned   bitpos;
    int unsigned   idx;
    logic [7:0]    mask;
    logic [7:0]    b;
    r.unit_write   = 1'b0;
    r.unit_index   = '0;
    r.line_address = '0;
    r.segment_bits = '0;
    r.pixel_lit    = 1'b0;
    r.err          = ERR_OK;
    // a zero unit size behaves as one
    uw = (unit_w == 0) ? 1 : unit_w;
    uh = (unit_h == 0) ? 1 : unit_h;
    if (x >= mat_w || y >= mat_h) begin
      r.err = ERR_BOUNDS;
      return r;
    end
    unit   = (y / uh) * across + x / uw;
    // oversized units wrap into the remap tables
    line   = 32'((line_map >> (4 * ((y % uh) & 15))) & 64'hf);
    bitpos = 32'((bit_map >> (3 * ((x % uw) & 7))) & 24'h7);
    idx    = line + uh * unit;
    if (idx >= DEPTH || unit >= UNITS_MAX) begin
      r.err = ERR_STORE;
      return r;
    end
    mask           = 8'd1 << bitpos;
    r.unit_index   = unit[3:0];
    r.line_address = line[3:0];
    if (op == OP_READ) begin
      b              = live_store[idx];
      r.segment_bits = b;
      r.pixel_lit    = |(b & mask);
      return r;
    end
    b = wr_through ? live_store[idx] : shadow_store[idx];
    if (c >= LIT_LEVEL) begin
      b = b | mask;
    end else begin
      b = b & ~mask;
    end
    // shadow draws still report unit, line and byte, just no unit write
    if (wr_through) begin
      live_store[idx] = b;
      r.unit_write    = 1'b1;
    end else begin
      shadow_store[idx] = b;
    end
    r.segment_bits = b;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Error reporting
  // ---------------------------------------------------------------------------
  task automatic flag_error(string what);
    $display("ERROR @%0t: %s", $time, what);
    errors++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s got %0h, expected %0h", name, got, want));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, and the check of every accepted word.
  // Outputs are sampled at the rising edge, before it takes effect.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= idle_on && ($urandom_range(0, 99) < 20);
  end

  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        flag_error("result word with nothing outstanding");
      end else begin
        want = pending.pop_front();
        check_field("unit_write", unit_write, want.unit_write);
        check_field("unit_index", unit_index, want.unit_index);
        check_field("line_address", line_address, want.line_address);
        check_field("segment_bits", segment_bits, want.segment_bits);
        check_field("pixel_lit", pixel_lit, want.pixel_lit);
        check_field("error_code", error_code, want.err);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("led_matrix_pixel_mapper: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Inputs change on the falling edge; a handshake completes at the
  // rising edge where valid is high and stall is low.
  // ---------------------------------------------------------------------------

  // Send one draw/read word; in_valid stays high afterwards so the next word
  // can follow back to back. Callers that stop sending use wait_drained.
  task automatic send_word(logic op, logic [7:0] x, logic [7:0] y, logic [15:0] c);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    opcode   <= op;
    pixel_x  <= x;
    pixel_y  <= y;
    colour   <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending.push_back(map_pixel(op, x, y, c));
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
  endtask

  // Register write; the bench copy follows on the accepting edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MATRIX_WIDTH:  mat_w      = data[7:0];
      REG_MATRIX_HEIGHT: mat_h      = data[7:0];
      REG_UNITS_ACROSS:  across     = data[4:0];
      REG_UNIT_WIDTH:    unit_w     = data[3:0];
      REG_UNIT_HEIGHT:   unit_h     = data[4:0];
      REG_BIT_REMAP:     bit_map    = data[23:0];
      REG_LINE_REMAP:    line_map   = data;
      REG_WRITE_THROUGH: wr_through = data[0];
      default: ;  // unlisted index, ignored by the block
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Full layout load; the block must be idle.
  task automatic load_layout(logic [7:0] w, logic [7:0] h, logic [4:0] a, logic [3:0] uw,
                             logic [4:0] uh, logic [23:0] bm, logic [63:0] lm, logic wt);
    write_reg(REG_MATRIX_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_MATRIX_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_UNITS_ACROSS, CFG_DATA_W'(a));
    write_reg(REG_UNIT_WIDTH, CFG_DATA_W'(uw));
    write_reg(REG_UNIT_HEIGHT, CFG_DATA_W'(uh));
    write_reg(REG_BIT_REMAP, CFG_DATA_W'(bm));
    write_reg(REG_LINE_REMAP, lm);
    write_reg(REG_WRITE_THROUGH, CFG_DATA_W'(wt));
  endtask

  // Random layout: mostly one that fits the store, so draws land and reads
  // see them; otherwise anything the register fields can hold.
  task automatic random_layout();
    int          uw;
    int          uh;
    int          acr;
    int          rows;
    int          i;
    logic [63:0] lm;
    logic        wt;
    wt = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 99) < 65) begin
      uw   = $urandom_range(1, 8);
      uh   = $urandom_range(1, 8);
      acr  = $urandom_range(1, 4);
      rows = (DEPTH / uh) / acr;
      if (rows > UNITS_MAX / acr) rows = UNITS_MAX / acr;
      if (rows < 1) rows = 1;
      lm = '0;
      for (i = 0; i < 16; i++) lm[4*i +: 4] = 4'($urandom_range(0, uh - 1));
      load_layout(8'(acr * uw), 8'(rows * uh), 5'(acr), 4'(uw), 5'(uh), 24'($urandom),
                  lm, wt);
    end else begin
      load_layout(8'($urandom), 8'($urandom), 5'($urandom), 4'($urandom), 5'($urandom),
                  24'($urandom), {$urandom, $urandom}, wt);
    end
  endtask

  // Random word: mostly inside the matrix, some anywhere; colour split about
  // evenly between lit and dark.
  task automatic random_word();
    logic        op;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] c;
    op = ($urandom_range(0, 99) < 40) ? OP_READ : OP_DRAW;
    if ($urandom_range(0, 1)) begin
      c = 16'($urandom);
    end else begin
      c = 16'($urandom_range(0, int'(LIT_LEVEL)));
    end
    if ($urandom_range(0, 99) < 10 || mat_w == 0 || mat_h == 0) begin
      x = 8'($urandom);
      y = 8'($urandom);
    end else begin
      x = 8'($urandom_range(0, mat_w - 1));
      y = 8'($urandom_range(0, mat_h - 1));
    end
    send_word(op, x, y, c);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Power-on layout: corners, the lit threshold, and coordinates off the matrix.
  task automatic test_power_on_layout();
    send_word(OP_DRAW, 0, 0, 16'hffff);
    send_word(OP_READ, 0, 0, 16'h0000);
    send_word(OP_DRAW, 34, 10, LIT_LEVEL);
    send_word(OP_READ, 34, 10, 16'hffff);
    send_word(OP_DRAW, 34, 10, LIT_LEVEL - 16'd1);
    send_word(OP_READ, 34, 10, 16'h0000);
    send_word(OP_DRAW, 35, 0, 16'hffff);    // right of the matrix
    send_word(OP_DRAW, 0, 11, 16'hffff);    // below the matrix
    send_word(OP_READ, 255, 255, 16'h0000);
  endtask

  // Zero unit sizes act as one; oversized units wrap into the remap tables;
  // unit count and store index limits.
  task automatic test_unit_size_corners();
    wait_drained();
    load_layout(255, 255, 16, 0, 0, 24'hFAC688, 64'hFEDCBA9876543210, 1'b1);
    send_word(OP_DRAW, 3, 0, 16'hffff);
    send_word(OP_DRAW, 15, 0, 16'hffff);    // last unit
    send_word(OP_DRAW, 0, 1, 16'hffff);     // one unit too many
    send_word(OP_READ, 3, 0, 16'h0000);
    wait_drained();
    load_layout(255, 255, 1, 15, 31, 24'($urandom), 64'hFEDCBA9876543210, 1'b1);
    send_word(OP_DRAW, 12, 20, 16'hffff);
    send_word(OP_DRAW, 14, 30, 16'hffff);
    send_word(OP_DRAW, 30, 1, 16'hffff);    // last store entry
    send_word(OP_DRAW, 30, 2, 16'hffff);    // one past the store
    send_word(OP_READ, 12, 20, 16'h0000);
  endtask

  // Shadow draws leave the live store alone; unlisted registers are ignored.
  task automatic test_shadow_and_unlisted_regs();
    logic [CFG_IDX_W-1:0] spare;
    wait_drained();
    load_layout(35, 11, 5, 7, 11, 24'hFAC688, 64'hFEDCBA9876543210, 1'b0);
    send_word(OP_DRAW, 5, 5, 16'hffff);
    send_word(OP_READ, 5, 5, 16'h0000);
    wait_drained();
    spare = CFG_IDX_W'($urandom_range(int'(REG_WRITE_THROUGH) + 1, (1 << CFG_IDX_W) - 1));
    write_reg(spare, {$urandom, $urandom});
    write_reg({CFG_IDX_W{1'b1}}, {$urandom, $urandom});
    write_reg(REG_WRITE_THROUGH, CFG_DATA_W'(1));
    send_word(OP_DRAW, 5, 5, 16'h0000);
    send_word(OP_READ, 5, 5, 16'h0000);
  endtask

  // Random words over a series of layouts: the largest and the smallest first,
  // then random ones. One phase runs with no gaps or stalls, and one stops
  // sending midway until the block has drained.
  task automatic test_random_layouts();
    int p;
    int n;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      idle_on = (p != 4);
      wait_drained();
      if (p == 0) begin
        load_layout(255, 255, 16, 8, 16, '1, '1, 1'b1);
      end else if (p == 1) begin
        load_layout(1, 1, 1, 1, 1, '0, '0, 1'($urandom_range(0, 1)));
      end else begin
        random_layout();
      end
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (p == 6 && n == PHASE_WORDS / 2) wait_drained();
        random_word();
      end
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    errors    = 0;
    cycles    = 0;
    idle_on   = 1'b1;
    rst       = 1'b1;
    in_valid  = 1'b0;
    opcode    = OP_DRAW;
    pixel_x   = '0;
    pixel_y   = '0;
    colour    = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_MATRIX_WIDTH;
    cfg_data  = '0;
    // register defaults and empty stores, as after reset
    mat_w      = 8'd35;
    mat_h      = 8'd11;
    across     = 5'd5;
    unit_w     = 4'd7;
    unit_h     = 5'd11;
    bit_map    = 24'hFAC688;
    line_map   = 64'hFEDCBA9876543210;
    wr_through = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      live_store[i]   = '0;
      shadow_store[i] = '0;
    end
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_power_on_layout();
    test_unit_size_corners();
    test_shadow_and_unlisted_regs();
    test_random_layouts();

    // let any stray word show up before the verdict
    wait_drained();
    repeat (2 * LATENCY) @(negedge clk);
    if (errors == 0) begin
      $display("led_matrix_pixel_mapper: match");
    end else begin
      $display("led_matrix_pixel_mapper: mismatch");
    end
    $finish;
  end

endmodule

FILE: led_matrix_pixel_mapper.f
rtl/lmpm_pkg.sv
rtl/lmpm_ram.sv
rtl/lmpm_div.sv
rtl/led_matrix_pixel_mapper.sv
bench/tb_led_matrix_pixel_mapper.sv
